/* src/bcd_pkg.sv */
package bcd_pkg;

	// Frame and block limits.
	localparam int MaxWidth  = 4096;
	localparam int MaxHeight = 4096;
	localparam int MaxBlock  = 64;
	localparam int MinBlock  = 4;

	// Field and register widths.
	localparam int ChanW   = 8;
	localparam int DimW    = 13;
	localparam int CoordW  = 12;
	localparam int InBlkW  = $clog2(MaxBlock);
	localparam int BlkSzW  = InBlkW + 1;
	localparam int ThrW    = 9;
	localparam int CountW  = 13;
	localparam int TagW    = 8;

	// Column counter memory: one entry per block column of the widest frame.
	localparam int CountDepth = (MaxWidth + MinBlock - 1) / MinBlock;
	localparam int IdxW       = $clog2(CountDepth);
	localparam int FillW      = IdxW + 1;
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	// Queue between the front and back parts, and the result queue.
	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int ResDepth   = 2;
	localparam int ResPtrW    = $clog2(ResDepth);

	// Configuration port.
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 13;
	localparam logic [CfgIdxW-1:0] RegFrameWidth  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegFrameHeight = 3'd1;
	localparam logic [CfgIdxW-1:0] RegBlockSize   = 3'd2;
	localparam logic [CfgIdxW-1:0] RegDiffLimit   = 3'd3;
	localparam logic [CfgIdxW-1:0] RegMinChanged  = 3'd4;
	localparam logic [CfgIdxW-1:0] RegWindowTag   = 3'd5;

	// Register values after reset.
	localparam logic [DimW-1:0]   FrameWidthReset  = 13'd640;
	localparam logic [DimW-1:0]   FrameHeightReset = 13'd480;
	localparam logic [BlkSzW-1:0] BlockSizeReset   = 7'd24;
	localparam logic [ThrW-1:0]   DiffLimitReset   = 9'd35;
	localparam logic [CountW-1:0] MinChangedReset  = 13'd24;
	localparam logic [TagW-1:0]   WindowTagReset   = 8'd0;

	typedef struct packed {
		logic [DimW-1:0]   frame_width;
		logic [DimW-1:0]   frame_height;
		logic [BlkSzW-1:0] block_size;
		logic [ThrW-1:0]   diff_limit;
		logic [CountW-1:0] min_changed;
		logic [TagW-1:0]   window_tag;
	} bcd_cfg_t;

	// One classified pixel on its way to the counting part.
	typedef struct packed {
		logic              changed;
		logic              first;
		logic              last_pixel;
		logic [IdxW-1:0]   idx;
		logic [CoordW-1:0] block_x;
		logic [CoordW-1:0] block_y;
		logic [BlkSzW-1:0] block_width;
		logic [BlkSzW-1:0] block_height;
	} bcd_item_t;

	typedef struct packed {
		logic [TagW-1:0]   tag;
		logic [CoordW-1:0] block_x;
		logic [CoordW-1:0] block_y;
		logic [BlkSzW-1:0] block_width;
		logic [BlkSzW-1:0] block_height;
		logic [CountW-1:0] change_count;
	} bcd_result_t;

endpackage

/* src/bcd_front.sv */
module bcd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bcd_pkg::bcd_cfg_t           cfg,
	input  logic                        push,
	output logic                        full,
	input  logic [bcd_pkg::ChanW-1:0]   prev_red,
	input  logic [bcd_pkg::ChanW-1:0]   prev_green,
	input  logic [bcd_pkg::ChanW-1:0]   prev_blue,
	input  logic [bcd_pkg::ChanW-1:0]   curr_red,
	input  logic [bcd_pkg::ChanW-1:0]   curr_green,
	input  logic [bcd_pkg::ChanW-1:0]   curr_blue,
	output logic                        q_push,
	output bcd_pkg::bcd_item_t          q_item,
	input  logic                        q_full
);

	function automatic logic [bcd_pkg::ChanW-1:0] abs_diff(
		input logic [bcd_pkg::ChanW-1:0] a,
		input logic [bcd_pkg::ChanW-1:0] b
	);
		abs_diff = (a > b) ? a - b : b - a;
	endfunction

	logic [bcd_pkg::CoordW-1:0] pix_col_q;
	logic [bcd_pkg::CoordW-1:0] pix_row_q;
	logic [bcd_pkg::InBlkW-1:0] col_in_blk_q;
	logic [bcd_pkg::InBlkW-1:0] row_in_blk_q;
	logic [bcd_pkg::CoordW-1:0] blk_col_q;

	logic                       s1_valid_q;
	bcd_pkg::bcd_item_t         item_s1;
	bcd_pkg::bcd_item_t         item_d;

	logic [bcd_pkg::ChanW-1:0]  diff_r, diff_g, diff_b, diff_rg, diff_max;
	logic [bcd_pkg::DimW-1:0]   fw_c, fh_c;
	logic [bcd_pkg::BlkSzW-1:0] bs_c;
	logic                       end_row, end_col_blk, end_frame, end_row_blk;
	logic                       accept;

	// Largest channel difference.
	always_comb begin
		diff_r   = abs_diff(prev_red, curr_red);
		diff_g   = abs_diff(prev_green, curr_green);
		diff_b   = abs_diff(prev_blue, curr_blue);
		diff_rg  = (diff_g > diff_r) ? diff_g : diff_r;
		diff_max = (diff_b > diff_rg) ? diff_b : diff_rg;
	end

	// Frame and block sizes held to their legal ranges.
	always_comb begin
		if (cfg.frame_width == '0) begin
			fw_c = bcd_pkg::DimW'(1);
		end else if (cfg.frame_width > bcd_pkg::DimW'(bcd_pkg::MaxWidth)) begin
			fw_c = bcd_pkg::DimW'(bcd_pkg::MaxWidth);
		end else begin
			fw_c = cfg.frame_width;
		end
		if (cfg.frame_height == '0) begin
			fh_c = bcd_pkg::DimW'(1);
		end else if (cfg.frame_height > bcd_pkg::DimW'(bcd_pkg::MaxHeight)) begin
			fh_c = bcd_pkg::DimW'(bcd_pkg::MaxHeight);
		end else begin
			fh_c = cfg.frame_height;
		end
		if (cfg.block_size < bcd_pkg::BlkSzW'(bcd_pkg::MinBlock)) begin
			bs_c = bcd_pkg::BlkSzW'(bcd_pkg::MinBlock);
		end else if (cfg.block_size > bcd_pkg::BlkSzW'(bcd_pkg::MaxBlock)) begin
			bs_c = bcd_pkg::BlkSzW'(bcd_pkg::MaxBlock);
		end else begin
			bs_c = cfg.block_size;
		end
	end

	// Row, block and frame boundaries at the current position.
	always_comb begin
		end_row     = ({1'b0, pix_col_q} + bcd_pkg::DimW'(1)) >= fw_c;
		end_col_blk = end_row ||
			(({1'b0, col_in_blk_q} + bcd_pkg::BlkSzW'(1)) >= bs_c);
		end_frame   = ({1'b0, pix_row_q} + bcd_pkg::DimW'(1)) >= fh_c;
		end_row_blk = end_frame ||
			(({1'b0, row_in_blk_q} + bcd_pkg::BlkSzW'(1)) >= bs_c);
	end

	// Classified item for the counting part.
	always_comb begin
		item_d.changed    = {1'b0, diff_max} >= cfg.diff_limit;
		item_d.first      = (row_in_blk_q == '0) && (col_in_blk_q == '0);
		item_d.last_pixel = end_col_blk && end_row_blk;
		if (blk_col_q > bcd_pkg::CoordW'(bcd_pkg::CountDepth - 1)) begin
			item_d.idx = bcd_pkg::IdxW'(bcd_pkg::CountDepth - 1);
		end else begin
			item_d.idx = blk_col_q[bcd_pkg::IdxW-1:0];
		end
		item_d.block_x      = pix_col_q - {{(bcd_pkg::CoordW - bcd_pkg::InBlkW){1'b0}},
			col_in_blk_q};
		item_d.block_y      = pix_row_q - {{(bcd_pkg::CoordW - bcd_pkg::InBlkW){1'b0}},
			row_in_blk_q};
		item_d.block_width  = {1'b0, col_in_blk_q} + bcd_pkg::BlkSzW'(1);
		item_d.block_height = {1'b0, row_in_blk_q} + bcd_pkg::BlkSzW'(1);
	end

	assign full   = s1_valid_q && q_full;
	assign accept = push && !full;
	assign q_push = s1_valid_q && !q_full;
	assign q_item = item_s1;

	// Raster position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_col_q    <= '0;
			pix_row_q    <= '0;
			col_in_blk_q <= '0;
			row_in_blk_q <= '0;
			blk_col_q    <= '0;
		end else if (accept) begin
			if (end_row) begin
				pix_col_q    <= '0;
				col_in_blk_q <= '0;
				blk_col_q    <= '0;
				if (end_frame) begin
					pix_row_q    <= '0;
					row_in_blk_q <= '0;
				end else begin
					pix_row_q    <= pix_row_q + bcd_pkg::CoordW'(1);
					row_in_blk_q <= end_row_blk ? '0 :
						row_in_blk_q + bcd_pkg::InBlkW'(1);
				end
			end else begin
				pix_col_q <= pix_col_q + bcd_pkg::CoordW'(1);
				if (end_col_blk) begin
					col_in_blk_q <= '0;
					blk_col_q    <= blk_col_q + bcd_pkg::CoordW'(1);
				end else begin
					col_in_blk_q <= col_in_blk_q + bcd_pkg::InBlkW'(1);
				end
			end
		end
	end

	// Output stage of the front part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept || (s1_valid_q && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* src/bcd_queue.sv */
module bcd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bcd_pkg::bcd_item_t din,
	output logic               full,
	input  logic               pop,
	output bcd_pkg::bcd_item_t dout,
	output logic               empty
);

	bcd_pkg::bcd_item_t          slot_q [bcd_pkg::QueueDepth];
	logic [bcd_pkg::QPtrW-1:0]   wr_ptr_q;
	logic [bcd_pkg::QPtrW-1:0]   rd_ptr_q;
	logic [bcd_pkg::QPtrW:0]     count_q;
	logic                        do_push, do_pop;

	assign full    = count_q == (bcd_pkg::QPtrW + 1)'(bcd_pkg::QueueDepth);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + bcd_pkg::QPtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + bcd_pkg::QPtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (bcd_pkg::QPtrW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (bcd_pkg::QPtrW + 1)'(1);
			end
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

/* src/bcd_back.sv */
module bcd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bcd_pkg::bcd_cfg_t           cfg,
	input  logic                        q_empty,
	input  bcd_pkg::bcd_item_t          q_item,
	output logic                        q_pop,
	input  logic                        pop,
	output logic                        empty,
	output logic [bcd_pkg::TagW-1:0]    tag,
	output logic [bcd_pkg::CoordW-1:0]  block_x,
	output logic [bcd_pkg::CoordW-1:0]  block_y,
	output logic [bcd_pkg::BlkSzW-1:0]  block_width,
	output logic [bcd_pkg::BlkSzW-1:0]  block_height,
	output logic [bcd_pkg::CountW-1:0]  change_count
);

	// Column counter memory; entries at or above the fill mark read as zero.
	logic [bcd_pkg::CountW-1:0] count_mem [bcd_pkg::CountDepth];
	logic [bcd_pkg::CountW-1:0] rd_data_q;
	logic [bcd_pkg::FillW-1:0]  fill_q;

	// Last counter write, forwarded past the memory read.
	logic                       lw_valid_q;
	logic [bcd_pkg::IdxW-1:0]   lw_idx_q;
	logic [bcd_pkg::CountW-1:0] lw_cnt_q;

	logic                       s2_valid_q;
	bcd_pkg::bcd_item_t         item_s2;
	logic                       hit_s2;
	logic                       s2_adv;
	logic [bcd_pkg::CountW-1:0] cnt_base, cnt_next;
	logic                       report;

	// Result queue.
	bcd_pkg::bcd_result_t        res_q [bcd_pkg::ResDepth];
	logic [bcd_pkg::ResPtrW-1:0] res_wr_q;
	logic [bcd_pkg::ResPtrW-1:0] res_rd_q;
	logic [bcd_pkg::ResPtrW:0]   res_cnt_q;
	logic                        res_full, res_push, res_pop;
	bcd_pkg::bcd_result_t        res_d;

	// Counter update for the pixel in the counting stage.
	always_comb begin
		if (item_s2.first) begin
			cnt_base = '0;
		end else if (lw_valid_q && (lw_idx_q == item_s2.idx)) begin
			cnt_base = lw_cnt_q;
		end else if (hit_s2) begin
			cnt_base = rd_data_q;
		end else begin
			cnt_base = '0;
		end
		if (item_s2.changed && (cnt_base != bcd_pkg::CountMax)) begin
			cnt_next = cnt_base + bcd_pkg::CountW'(1);
		end else begin
			cnt_next = cnt_base;
		end
		report = item_s2.last_pixel && (cnt_next >= cfg.min_changed);
	end

	assign res_full = res_cnt_q == (bcd_pkg::ResPtrW + 1)'(bcd_pkg::ResDepth);
	assign s2_adv   = s2_valid_q && !(report && res_full);
	assign q_pop    = !q_empty && (!s2_valid_q || s2_adv);
	assign res_push = s2_adv && report;
	assign empty    = res_cnt_q == '0;
	assign res_pop  = pop && !empty;

	always_comb begin
		res_d.tag          = cfg.window_tag;
		res_d.block_x      = item_s2.block_x;
		res_d.block_y      = item_s2.block_y;
		res_d.block_width  = item_s2.block_width;
		res_d.block_height = item_s2.block_height;
		res_d.change_count = cnt_next;
	end

	// Counter memory: read when a pixel enters the stage, write when it leaves.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_data_q <= count_mem[q_item.idx];
			item_s2   <= q_item;
			hit_s2    <= {1'b0, q_item.idx} < fill_q;
		end
		if (s2_adv) begin
			count_mem[item_s2.idx] <= cnt_next;
			lw_idx_q               <= item_s2.idx;
			lw_cnt_q               <= cnt_next;
		end
	end

	// Stage valid, fill mark and forwarding valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			fill_q     <= '0;
			lw_valid_q <= 1'b0;
		end else begin
			s2_valid_q <= q_pop || (s2_valid_q && !s2_adv);
			if (s2_adv) begin
				lw_valid_q <= 1'b1;
				if ({1'b0, item_s2.idx} >= fill_q) begin
					fill_q <= {1'b0, item_s2.idx} + bcd_pkg::FillW'(1);
				end
			end
		end
	end

	// Result queue pointers and level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (res_push) begin
				res_wr_q <= res_wr_q + bcd_pkg::ResPtrW'(1);
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + bcd_pkg::ResPtrW'(1);
			end
			if (res_push && !res_pop) begin
				res_cnt_q <= res_cnt_q + (bcd_pkg::ResPtrW + 1)'(1);
			end else if (res_pop && !res_push) begin
				res_cnt_q <= res_cnt_q - (bcd_pkg::ResPtrW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wr_q] <= res_d;
		end
	end

	assign tag          = res_q[res_rd_q].tag;
	assign block_x      = res_q[res_rd_q].block_x;
	assign block_y      = res_q[res_rd_q].block_y;
	assign block_width  = res_q[res_rd_q].block_width;
	assign block_height = res_q[res_rd_q].block_height;
	assign change_count = res_q[res_rd_q].change_count;

	// Counter writes only extend the written prefix by one entry at most.
	a_write_in_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		s2_adv |-> ({1'b0, item_s2.idx} <= fill_q))
		else $error("counter write skips past the fill mark");

	// The fill mark never moves back.
	a_fill_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |=> (fill_q >= $past(fill_q)))
		else $error("fill mark decreased");

	// A pixel held in the counting stage keeps its contents.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && !s2_adv) |=> (s2_valid_q && $stable(item_s2)))
		else $error("stalled counting stage lost its item");

endmodule

/* src/block_change_detector_top.sv */
// Block change detector.
// Input channel: a pixel pair (previous and current frame, RGB) is taken at a
// clock edge with push high and full low, in raster order. Result channel: the
// oldest block report is on the result ports while empty is low and is taken
// at an edge with pop high. A report carries the window tag, block position,
// clipped block size and its count of changed pixels.
// Configuration: cfg_wr_en writes cfg_data into the register chosen by
// cfg_index at the next edge; write only while no item is in flight.
// Throughput is one pixel per cycle while full is low. A report becomes
// visible after its block's last pixel has passed the classifying stage,
// the queue and the counting stage and entered the result queue; the counting
// stage's counter memory is read as the pixel enters and written as it leaves.
// Reset clears positions, queues and the counter fill mark and loads the
// default register values; no clearing pass is needed. When the receiver
// stalls, two reports wait in the result queue, then the counting stage,
// the four-entry queue and the input stage fill and full rises.
module block_change_detector_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bcd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bcd_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic [bcd_pkg::ChanW-1:0]     prev_red,
	input  logic [bcd_pkg::ChanW-1:0]     prev_green,
	input  logic [bcd_pkg::ChanW-1:0]     prev_blue,
	input  logic [bcd_pkg::ChanW-1:0]     curr_red,
	input  logic [bcd_pkg::ChanW-1:0]     curr_green,
	input  logic [bcd_pkg::ChanW-1:0]     curr_blue,
	input  logic                          pop,
	output logic                          empty,
	output logic [bcd_pkg::TagW-1:0]      tag,
	output logic [bcd_pkg::CoordW-1:0]    block_x,
	output logic [bcd_pkg::CoordW-1:0]    block_y,
	output logic [bcd_pkg::BlkSzW-1:0]    block_width,
	output logic [bcd_pkg::BlkSzW-1:0]    block_height,
	output logic [bcd_pkg::CountW-1:0]    change_count
);

	bcd_pkg::bcd_cfg_t  cfg_q;
	logic               fq_push, fq_full, fq_pop, fq_empty;
	bcd_pkg::bcd_item_t fq_din, fq_dout;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= bcd_pkg::FrameWidthReset;
			cfg_q.frame_height <= bcd_pkg::FrameHeightReset;
			cfg_q.block_size   <= bcd_pkg::BlockSizeReset;
			cfg_q.diff_limit   <= bcd_pkg::DiffLimitReset;
			cfg_q.min_changed  <= bcd_pkg::MinChangedReset;
			cfg_q.window_tag   <= bcd_pkg::WindowTagReset;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bcd_pkg::RegFrameWidth: begin
					cfg_q.frame_width <= cfg_data[bcd_pkg::DimW-1:0];
				end
				bcd_pkg::RegFrameHeight: begin
					cfg_q.frame_height <= cfg_data[bcd_pkg::DimW-1:0];
				end
				bcd_pkg::RegBlockSize: begin
					cfg_q.block_size <= cfg_data[bcd_pkg::BlkSzW-1:0];
				end
				bcd_pkg::RegDiffLimit: begin
					cfg_q.diff_limit <= cfg_data[bcd_pkg::ThrW-1:0];
				end
				bcd_pkg::RegMinChanged: begin
					cfg_q.min_changed <= cfg_data[bcd_pkg::CountW-1:0];
				end
				bcd_pkg::RegWindowTag: begin
					cfg_q.window_tag <= cfg_data[bcd_pkg::TagW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Classifying front part.
	bcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.prev_red   (prev_red),
		.prev_green (prev_green),
		.prev_blue  (prev_blue),
		.curr_red   (curr_red),
		.curr_green (curr_green),
		.curr_blue  (curr_blue),
		.q_push     (fq_push),
		.q_item     (fq_din),
		.q_full     (fq_full)
	);

	// Decoupling queue.
	bcd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.din    (fq_din),
		.full   (fq_full),
		.pop    (fq_pop),
		.dout   (fq_dout),
		.empty  (fq_empty)
	);

	// Counting and reporting back part.
	bcd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (fq_empty),
		.q_item       (fq_dout),
		.q_pop        (fq_pop),
		.pop          (pop),
		.empty        (empty),
		.tag          (tag),
		.block_x      (block_x),
		.block_y      (block_y),
		.block_width  (block_width),
		.block_height (block_height),
		.change_count (change_count)
	);

endmodule

/* sim/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bcd_pkg::*;

	localparam int ClkPeriod    = 10;
	localparam int ResetCycles  = 8;
	localparam int SettleCycles = 10;
	localparam int CycleLimit   = 400000;
	localparam int RandomItems  = 1900;
	localparam int IdlePercent  = 38;
	localparam int MaxReports   = 10;

	typedef struct packed {
		bit [ChanW-1:0] prev_red;
		bit [ChanW-1:0] prev_green;
		bit [ChanW-1:0] prev_blue;
		bit [ChanW-1:0] curr_red;
		bit [ChanW-1:0] curr_green;
		bit [ChanW-1:0] curr_blue;
	} pixel_t;

	// Tracks the detector's registers and position counters and keeps the block
	// reports that the accepted pixels are due to produce, oldest first.
	class block_report_checker;
		bit [DimW-1:0]   frame_width;
		bit [DimW-1:0]   frame_height;
		bit [BlkSzW-1:0] block_size;
		bit [ThrW-1:0]   diff_limit;
		bit [CountW-1:0] min_changed;
		bit [TagW-1:0]   window_tag;
		bit [CountW-1:0] column_counts [CountDepth];
		bit [CoordW-1:0] pixel_column;
		bit [CoordW-1:0] pixel_row;
		bit [CoordW-1:0] block_column;
		bit [InBlkW-1:0] column_in_block;
		bit [InBlkW-1:0] row_in_block;
		bcd_result_t     pending_reports [$];
		int              errors;

		function new();
			frame_width     = FrameWidthReset;
			frame_height    = FrameHeightReset;
			block_size      = BlockSizeReset;
			diff_limit      = DiffLimitReset;
			min_changed     = MinChangedReset;
			window_tag      = WindowTagReset;
			pixel_column    = '0;
			pixel_row       = '0;
			block_column    = '0;
			column_in_block = '0;
			row_in_block    = '0;
			errors          = 0;
		endfunction

		function int unsigned limit(int unsigned v, int unsigned lo, int unsigned hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function int unsigned chan_diff(bit [ChanW-1:0] a, bit [ChanW-1:0] b);
			return (a > b) ? a - b : b - a;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] value);
			case (index)
				RegFrameWidth:  frame_width  = value;
				RegFrameHeight: frame_height = value;
				RegBlockSize:   block_size   = value[BlkSzW-1:0];
				RegDiffLimit:   diff_limit   = value[ThrW-1:0];
				RegMinChanged:  min_changed  = value;
				RegWindowTag:   window_tag   = value[TagW-1:0];
				default: ;
			endcase
		endfunction

		function string show(bcd_result_t r);
			return $sformatf("tag %0d x %0d y %0d w %0d h %0d count %0d", r.tag, r.block_x,
				r.block_y, r.block_width, r.block_height, r.change_count);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MaxReports)
				$display("%s", msg);
		endfunction

		function int reports_due();
			return pending_reports.size();
		endfunction

		// Classify one pixel pair, update the block column's count and advance
		// the raster position; a block's last pixel may yield a report.
		function void take_pixel(pixel_t px);
			int unsigned fw, fh, bs, diff, cnt, idx;
			bit          hit, end_row, end_col_block, end_frame, end_row_block;
			bcd_result_t blk;
			fw = limit(frame_width, 1, MaxWidth);
			fh = limit(frame_height, 1, MaxHeight);
			bs = limit(block_size, MinBlock, MaxBlock);
			diff = chan_diff(px.prev_red, px.curr_red);
			if (chan_diff(px.prev_green, px.curr_green) > diff)
				diff = chan_diff(px.prev_green, px.curr_green);
			if (chan_diff(px.prev_blue, px.curr_blue) > diff)
				diff = chan_diff(px.prev_blue, px.curr_blue);
			hit = diff >= diff_limit;

			// The first pixel of a block restarts its column count.
			idx = (block_column < CountDepth) ? block_column : CountDepth - 1;
			cnt = (row_in_block == 0 && column_in_block == 0) ? 0 : column_counts[idx];
			if (hit && cnt < CountMax)
				cnt++;
			column_counts[idx] = CountW'(cnt);

			end_row       = pixel_column + 1 >= fw;
			end_col_block = end_row || column_in_block + 1 >= bs;
			end_frame     = pixel_row + 1 >= fh;
			end_row_block = end_frame || row_in_block + 1 >= bs;

			if (end_col_block && end_row_block && cnt >= min_changed) begin
				blk.tag          = window_tag;
				blk.block_x      = pixel_column - column_in_block;
				blk.block_y      = pixel_row - row_in_block;
				blk.block_width  = BlkSzW'(column_in_block + 1);
				blk.block_height = BlkSzW'(row_in_block + 1);
				blk.change_count = CountW'(cnt);
				pending_reports.push_back(blk);
			end

			// Advance the raster position.
			if (end_row) begin
				pixel_column    = '0;
				column_in_block = '0;
				block_column    = '0;
				if (end_frame) begin
					pixel_row    = '0;
					row_in_block = '0;
				end else begin
					pixel_row++;
					row_in_block = end_row_block ? '0 : InBlkW'(row_in_block + 1);
				end
			end else begin
				pixel_column++;
				if (end_col_block) begin
					column_in_block = '0;
					block_column++;
				end else begin
					column_in_block++;
				end
			end
		endfunction

		function void check_report(bcd_result_t got);
			bcd_result_t want;
			if (pending_reports.size() == 0) begin
				flag({"unexpected block report: ", show(got)});
				return;
			end
			want = pending_reports.pop_front();
			if (got.tag !== want.tag || got.block_x !== want.block_x ||
					got.block_y !== want.block_y || got.block_width !== want.block_width ||
					got.block_height !== want.block_height ||
					got.change_count !== want.change_count)
				flag($sformatf("block report mismatch: expected %s, got %s", show(want),
					show(got)));
		endfunction

		function void close_out();
			if (pending_reports.size() != 0)
				flag($sformatf("%0d block reports never arrived, oldest %s",
					pending_reports.size(), show(pending_reports[0])));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                push;
	logic                full;
	logic [ChanW-1:0]    prev_red;
	logic [ChanW-1:0]    prev_green;
	logic [ChanW-1:0]    prev_blue;
	logic [ChanW-1:0]    curr_red;
	logic [ChanW-1:0]    curr_green;
	logic [ChanW-1:0]    curr_blue;
	logic                pop;
	logic                empty;
	logic [TagW-1:0]     tag;
	logic [CoordW-1:0]   block_x;
	logic [CoordW-1:0]   block_y;
	logic [BlkSzW-1:0]   block_width;
	logic [BlkSzW-1:0]   block_height;
	logic [CountW-1:0]   change_count;

	block_report_checker board;
	bcd_result_t         seen_report;
	bit                  calm = 1'b0;
	int                  items_sent = 0;
	int                  cycles = 0;

	block_change_detector_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.prev_red     (prev_red),
		.prev_green   (prev_green),
		.prev_blue    (prev_blue),
		.curr_red     (curr_red),
		.curr_green   (curr_green),
		.curr_blue    (curr_blue),
		.pop          (pop),
		.empty        (empty),
		.tag          (tag),
		.block_x      (block_x),
		.block_y      (block_y),
		.block_width  (block_width),
		.block_height (block_height),
		.change_count (change_count)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	// Give up if the run hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The receiver stalls at random except during the calm stretch.
	always @(negedge clk) begin
		pop <= calm || ($urandom_range(99) >= IdlePercent);
	end

	// Every report taken from the block is checked against the oldest one due.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			seen_report = {tag, block_x, block_y, block_width, block_height, change_count};
			board.check_report(seen_report);
		end
	end

	function automatic pixel_t pair(int pr, int pg, int pb, int cr, int cg, int cb);
		pixel_t p;
		p.prev_red   = ChanW'(pr);
		p.prev_green = ChanW'(pg);
		p.prev_blue  = ChanW'(pb);
		p.curr_red   = ChanW'(cr);
		p.curr_green = ChanW'(cg);
		p.curr_blue  = ChanW'(cb);
		return p;
	endfunction

	// Move a channel by exactly delta where that fits, else by less.
	function automatic bit [ChanW-1:0] nudge(bit [ChanW-1:0] base, int unsigned delta);
		if (base + delta <= 255 && (base < delta || $urandom_range(1)))
			return ChanW'(base + delta);
		if (base >= delta)
			return ChanW'(base - delta);
		return (base > 127) ? 8'd0 : 8'd255;
	endfunction

	// Build a pixel pair that is changed or unchanged at the given threshold.
	function automatic pixel_t make_pixel(int unsigned thr, bit hit);
		bit [ChanW-1:0] pv [3];
		bit [ChanW-1:0] cv [3];
		bit [ChanW-1:0] swap;
		int unsigned    span;
		int unsigned    delta;
		int unsigned    c;
		for (int i = 0; i < 3; i++) begin
			pv[i] = ChanW'($urandom);
			cv[i] = ChanW'($urandom);
		end
		// One pair in ten keeps fully random channels.
		if ($urandom_range(9) != 0) begin
			span = (thr == 0) ? 0 : ((thr > 256) ? 255 : thr - 1);
			for (int i = 0; i < 3; i++)
				cv[i] = nudge(pv[i], $urandom_range(0, span));
			if (hit && thr <= 255) begin
				delta = ($urandom_range(3) == 0) ? thr : $urandom_range(thr, 255);
				c = $urandom_range(2);
				pv[c] = ChanW'($urandom_range(0, 255 - delta));
				cv[c] = ChanW'(pv[c] + delta);
				if ($urandom_range(1)) begin
					swap  = pv[c];
					pv[c] = cv[c];
					cv[c] = swap;
				end
			end
		end
		return pair(pv[0], pv[1], pv[2], cv[0], cv[1], cv[2]);
	endfunction

	// Write one register; entered and left away from any pixel traffic.
	task automatic write_reg(logic [CfgIdxW-1:0] index, int value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= CfgDataW'(value);
		@(posedge clk);
		board.set_reg(index, CfgDataW'(value));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic configure(int fw, int fh, int bs, int thr, int minc, int wtag);
		write_reg(RegFrameWidth, fw);
		write_reg(RegFrameHeight, fh);
		write_reg(RegBlockSize, bs);
		write_reg(RegDiffLimit, thr);
		write_reg(RegMinChanged, minc);
		write_reg(RegWindowTag, wtag);
	endtask

	// Offer one item after a random number of idle cycles and hold it until taken.
	task automatic send_pixel(pixel_t p);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < IdlePercent)
				gap++;
		@(negedge clk);
		repeat (gap) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push       <= 1'b1;
		prev_red   <= p.prev_red;
		prev_green <= p.prev_green;
		prev_blue  <= p.prev_blue;
		curr_red   <= p.curr_red;
		curr_green <= p.curr_green;
		curr_blue  <= p.curr_blue;
		do
			@(posedge clk);
		while (full);
		board.take_pixel(p);
		items_sent++;
	endtask

	// Stop pushing and wait until every report due has come out and the
	// pipeline has had time to finish pixels that report nothing.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (board.reports_due() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	initial begin
		int fw, fh, bs, thr, minc, wtag, pct, npix, fwe, fhe, bse, base, shape, pick;
		board      = new();
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		push       = 1'b0;
		pop        = 1'b0;
		prev_red   = '0;
		prev_green = '0;
		prev_blue  = '0;
		curr_red   = '0;
		curr_green = '0;
		curr_blue  = '0;
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A 5x3 frame cut into a full and a clipped block column, a threshold of
		// one, and a zero minimum so that empty blocks are reported too.
		configure(5, 3, 4, 1, 0, 255);
		send_pixel(pair(0, 0, 0, 0, 0, 0));
		send_pixel(pair(255, 255, 255, 255, 255, 255));
		send_pixel(pair(255, 0, 0, 0, 0, 0));
		send_pixel(pair(0, 255, 0, 0, 0, 0));
		send_pixel(pair(0, 0, 255, 0, 0, 0));
		send_pixel(pair(0, 0, 0, 255, 0, 0));
		send_pixel(pair(0, 0, 0, 0, 255, 0));
		send_pixel(pair(0, 0, 0, 0, 0, 255));
		send_pixel(pair(0, 0, 0, 255, 255, 255));
		send_pixel(pair(10, 20, 30, 11, 20, 30));
		send_pixel(pair(128, 128, 128, 127, 129, 128));
		send_pixel(pair(255, 255, 255, 0, 0, 0));
		send_pixel(pair(1, 2, 3, 1, 2, 3));
		send_pixel(pair(200, 100, 50, 199, 100, 50));
		send_pixel(pair(0, 255, 0, 255, 0, 255));
		drain();

		// Zero frame size acts as a single pixel, too small a block size as the
		// smallest one, and a zero threshold marks every pixel as changed.
		configure(0, 0, 3, 0, 1, 0);
		repeat (3) send_pixel(pair(77, 77, 77, 77, 77, 77));
		drain();

		// A threshold above 255 marks nothing, and an oversized block is capped.
		configure(2, 2, 127, 256, 0, 90);
		repeat (4) send_pixel(pair(0, 255, 0, 255, 0, 255));
		drain();

		// Random frames, each under its own register settings.
		base = items_sent;
		while (items_sent - base < RandomItems) begin
			calm = (items_sent - base >= 800) && (items_sent - base < 1150);
			fw = $urandom_range(1, 24);
			fh = $urandom_range(1, 16);
			bs = $urandom_range(4, 8);
			shape = $urandom_range(15);
			case (shape)
				0: fw = $urandom_range(1);
				1: fh = $urandom_range(1);
				2: begin
					fw = $urandom_range(60, 70);
					fh = $urandom_range(1, 3);
					bs = MaxBlock;
				end
				3: begin
					fw = $urandom_range(MaxWidth, 8191);
					fh = $urandom_range(MaxHeight, 8191);
					bs = $urandom_range(MaxBlock + 1, 127);
				end
				4: bs = $urandom_range(0, MinBlock - 1);
				5: bs = $urandom_range(9, 24);
				default: ;
			endcase
			fwe = (fw < 1) ? 1 : ((fw > MaxWidth) ? MaxWidth : fw);
			fhe = (fh < 1) ? 1 : ((fh > MaxHeight) ? MaxHeight : fh);
			bse = (bs < MinBlock) ? MinBlock : ((bs > MaxBlock) ? MaxBlock : bs);

			pick = $urandom_range(15);
			case (pick)
				0: thr = 0;
				1: thr = $urandom_range(256, 511);
				2: thr = 255;
				3: thr = 1;
				default: thr = $urandom_range(1, 255);
			endcase

			pick = $urandom_range(15);
			if (pick == 0)
				minc = 0;
			else if (pick == 1)
				minc = $urandom_range(4097, 8191);
			else if (pick < 9)
				minc = $urandom_range(1, 4);
			else
				minc = $urandom_range(1, bse * bse);
			wtag = $urandom_range(255);
			pct  = ($urandom_range(3) == 0) ? $urandom_range(0, 100) : $urandom_range(60, 100);

			// Mostly whole frames; now and then a part frame, so that the next
			// settings take over in the middle of a frame.
			npix = fwe * fhe;
			if (npix > 400 || $urandom_range(7) == 0)
				npix = $urandom_range(1, 200);

			configure(fw, fh, bs, thr, minc, wtag);
			repeat (npix) send_pixel(make_pixel(thr, $urandom_range(99) < pct));
			drain();
		end
		calm = 1'b0;

		board.close_out();
		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
src/bcd_pkg.sv
src/bcd_front.sv
src/bcd_queue.sv
src/bcd_back.sv
src/block_change_detector_top.sv
sim/tb_top.sv
